// ----- rtl/core/jms_pkg.sv -----
// Shared types and constants of the JPEG marker scanner.
package jms_pkg;

    localparam int OffsetBitsDefault = 32;
    localparam int FifoDepth         = 4;
    localparam int OutDataBits       = 96;

    localparam logic [7:0] MarkerPrefix = 8'hFF;
    localparam logic [7:0] NoType       = 8'h00;
    localparam logic       StatusFound  = 1'b0;
    localparam logic       StatusEnd    = 1'b1;

    typedef struct packed {
        logic        status;
        logic [7:0]  marker_type;
        logic [31:0] start_offset;
        logic [16:0] chunk_length;
        logic [31:0] end_offset;
        logic        last_result;
    } t_result;

    // Results produced by one accepted byte: none, one or two, first in order.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// ----- rtl/core/jpeg_marker_scanner.sv -----
// Top level of the JPEG marker scanner.
// Each result is registered in the result queue before it is offered on the master side.
// Throughput: one byte per cycle unless stalled; a byte's two results leave one by one.
// The input side stalls only while the four-entry result queue holds more than two results.
// Reset (synchronous, active low) clears the scan state, the queue and wanted_type.
module jpeg_marker_scanner
    import jms_pkg::*;
#(
    parameter int OFFSET_BITS = OffsetBitsDefault
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [7:0]             i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // data_byte
    input  logic                   s_axis_tlast,   // stream_end
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // marker_type[7:0], start_offset[39:8], chunk_length[56:40], end_offset[88:57], zeros
    output logic [OutDataBits-1:0] m_axis_tdata,
    output logic                   m_axis_tuser,   // status
    output logic                   m_axis_tlast    // last_result
);

    logic    fire;
    t_push   push;
    t_result head;

    assign fire = s_axis_tvalid && s_axis_tready;

    jms_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_push      (push)
    );

    jms_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ready (m_axis_tready),
        .o_room  (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_head  (head)
    );

    assign m_axis_tdata = {7'd0, head.end_offset, head.chunk_length,
                           head.start_offset, head.marker_type};
    assign m_axis_tuser = head.status;
    assign m_axis_tlast = head.last_result;

endmodule

// ----- rtl/core/jms_scan.sv -----
// Marker scan state machine: consumes one byte per transaction and forms its results.
module jms_scan
    import jms_pkg::*;
#(
    parameter int OFFSET_BITS = OffsetBitsDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_push      o_push
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LENHI,
        PH_LENLO,
        PH_SKIP
    } t_phase;

    t_phase                 r_phase,      n_phase;
    logic [OFFSET_BITS-1:0] r_byte_pos,   n_byte_pos;
    logic [OFFSET_BITS-1:0] r_marker_pos, n_marker_pos;
    logic [7:0]             r_cur_type,   n_cur_type;
    logic [7:0]             r_len_high,   n_len_high;
    logic [15:0]            r_skip,       n_skip;
    logic [7:0]             r_wanted;

    logic                   found_raw;
    logic                   match;
    logic [16:0]            size;
    logic [15:0]            len16;
    logic [OFFSET_BITS-1:0] end_full;
    logic [63:0]            start_wide;
    logic [63:0]            end_wide;
    t_result                found_res;
    t_result                end_res;

    always_comb begin
        n_phase      = r_phase;
        n_byte_pos   = r_byte_pos + OFFSET_BITS'(1);
        n_marker_pos = r_marker_pos;
        n_cur_type   = r_cur_type;
        n_len_high   = r_len_high;
        n_skip       = r_skip;
        found_raw    = 1'b0;
        size         = 17'd0;

        // Declared lengths below two are clamped so the scan never steps back.
        len16 = {r_len_high, i_byte};
        if (len16 < 16'd2) begin
            len16 = 16'd2;
        end

        unique case (r_phase)
            PH_TYPE: begin
                if (i_byte == NoType) begin
                    n_phase = PH_HUNT;
                end else begin
                    n_cur_type = i_byte;
                    n_phase    = PH_LENHI;
                end
            end
            PH_LENHI: begin
                // A prefix in place of the length ends a bare two-byte marker
                // and opens the next one.
                if (i_byte == MarkerPrefix) begin
                    found_raw    = 1'b1;
                    size         = 17'd2;
                    n_marker_pos = r_byte_pos;
                    n_phase      = PH_TYPE;
                end else begin
                    n_len_high = i_byte;
                    n_phase    = PH_LENLO;
                end
            end
            PH_LENLO: begin
                found_raw = 1'b1;
                size      = {1'b0, len16} + 17'd2;
                n_skip    = len16 - 16'd2;
                n_phase   = (n_skip != 16'd0) ? PH_SKIP : PH_HUNT;
            end
            PH_SKIP: begin
                n_skip = r_skip - 16'd1;
                if (n_skip == 16'd0) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_HUNT: begin
                if (i_byte == MarkerPrefix) begin
                    n_marker_pos = r_byte_pos;
                    n_phase      = PH_TYPE;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase

        if (i_last) begin
            n_phase      = PH_HUNT;
            n_byte_pos   = '0;
            n_marker_pos = '0;
            n_cur_type   = '0;
            n_len_high   = '0;
            n_skip       = '0;
        end
    end

    assign match      = found_raw && ((r_wanted == NoType) || (r_wanted == r_cur_type));
    assign end_full   = r_marker_pos + OFFSET_BITS'(size);
    assign start_wide = 64'(r_marker_pos);
    assign end_wide   = 64'(end_full);

    always_comb begin
        found_res.status       = StatusFound;
        found_res.marker_type  = r_cur_type;
        found_res.start_offset = start_wide[31:0];
        found_res.chunk_length = size;
        found_res.end_offset   = end_wide[31:0];
        found_res.last_result  = !i_last;

        end_res              = '0;
        end_res.status       = StatusEnd;
        end_res.last_result  = 1'b1;

        o_push.count  = i_fire ? (2'(match) + 2'(i_last)) : 2'd0;
        o_push.first  = match ? found_res : end_res;
        o_push.second = end_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_byte_pos   <= '0;
            r_marker_pos <= '0;
            r_cur_type   <= '0;
            r_len_high   <= '0;
            r_skip       <= '0;
            r_wanted     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_wanted <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_phase      <= n_phase;
                r_byte_pos   <= n_byte_pos;
                r_marker_pos <= n_marker_pos;
                r_cur_type   <= n_cur_type;
                r_len_high   <= n_len_high;
                r_skip       <= n_skip;
            end
        end
    end

endmodule

// ----- rtl/core/jms_fifo.sv -----
// Result queue: takes up to two results per cycle and presents one per transaction.
module jms_fifo
    import jms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_ready,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_head
);

    localparam int PtrW = $clog2(FifoDepth);
    localparam int CntW = PtrW + 1;

    t_result         r_mem [FifoDepth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count,  n_count;
    logic            pop;

    assign pop     = (r_count != '0) && i_ready;
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    // Room is kept for the two results that a single byte can produce.
    assign o_room  = (r_count <= CntW'(FifoDepth - 2));

    assign n_wr_ptr = r_wr_ptr + PtrW'(i_push.count);
    assign n_rd_ptr = r_rd_ptr + PtrW'(pop);
    assign n_count  = r_count + CntW'(i_push.count) - CntW'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + PtrW'(1)] <= i_push.second;
        end
    end

endmodule

// ----- rtl/core/jms_checker.sv -----
// Port-level assertions for the JPEG marker scanner and their binding to the top level.
module jms_checker
    import jms_pkg::*;
#(
    parameter int OFFSET_BITS = OffsetBitsDefault
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_cfg_we,
    input logic [7:0]             i_cfg_wdata,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [7:0]             s_axis_tdata,
    input logic                   s_axis_tlast,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OutDataBits-1:0] m_axis_tdata,
    input logic                   m_axis_tuser,
    input logic                   m_axis_tlast
);

    localparam logic [31:0] OffMask = (OFFSET_BITS >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << OFFSET_BITS) - 64'd1);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("master side dropped or changed a stalled transaction");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == StatusEnd) |->
            (m_axis_tdata == '0) && m_axis_tlast)
        else $error("end-of-data result is not empty or not last");

    a_end_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == StatusFound) |->
            m_axis_tdata[88:57] ==
            ((m_axis_tdata[39:8] + 32'(m_axis_tdata[56:40])) & OffMask))
        else $error("end offset does not match start plus chunk length");

    a_found_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == StatusFound) |->
            (m_axis_tdata[56:40] >= 17'd2) && (m_axis_tdata[7:0] != NoType) &&
            (m_axis_tdata[95:89] == 7'd0))
        else $error("found result has an impossible type or length");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

endmodule

bind jpeg_marker_scanner jms_checker #(.OFFSET_BITS(OFFSET_BITS)) u_jms_checker (.*);

// ----- test/tb_top.sv -----
// Testbench of the JPEG marker scanner: directed and random byte streams, checked per result.
`timescale 1ns / 1ps

module tb_top;
    import jms_pkg::*;

    localparam int CycleLimit   = 2_000_000;
    localparam int RandomBytes  = 1700;
    localparam int SettleCycles = 4;

    typedef enum logic [2:0] {
        SCAN_HUNT,
        SCAN_TYPE,
        SCAN_LEN_HI,
        SCAN_LEN_LO,
        SCAN_SKIP
    } t_scan_phase;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [7:0]             i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // data_byte
    logic                   s_axis_tlast;   // stream_end
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // marker_type[7:0], start_offset[39:8], chunk_length[56:40], end_offset[88:57], zeros
    logic [OutDataBits-1:0] m_axis_tdata;
    logic                   m_axis_tuser;   // status
    logic                   m_axis_tlast;   // last_result

    jpeg_marker_scanner dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // Scanner state mirrored by the testbench.
    t_scan_phase scan_phase;
    logic [31:0] byte_pos;
    logic [31:0] marker_pos;
    logic [7:0]  cur_type;
    logic [7:0]  len_hi;
    logic [15:0] skip_left;
    logic [7:0]  wanted_cfg;

    t_result     pending_results[$];
    logic [7:0]  stream_bytes[$];
    int          fail_count;
    int          send_gap_max;
    int          recv_stall_max;

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    task automatic clear_scan();
        scan_phase = SCAN_HUNT;
        byte_pos   = '0;
        marker_pos = '0;
        cur_type   = NoType;
        len_hi     = '0;
        skip_left  = '0;
    endtask

    // Works out the results one accepted byte causes and queues them.
    task automatic scan_byte(input logic [7:0] b, input logic stream_end);
        t_result     res;
        logic        chunk_done;
        logic [16:0] chunk_size;
        logic [16:0] declared;
        logic [31:0] chunk_start;
        chunk_done  = 1'b0;
        chunk_size  = '0;
        chunk_start = marker_pos;
        case (scan_phase)
            SCAN_TYPE: begin
                if (b == NoType) begin
                    scan_phase = SCAN_HUNT;
                end else begin
                    cur_type   = b;
                    scan_phase = SCAN_LEN_HI;
                end
            end
            SCAN_LEN_HI: begin
                if (b == MarkerPrefix) begin
                    // Two-byte chunk; this 0xFF opens the next marker.
                    chunk_done = 1'b1;
                    chunk_size = 17'd2;
                    marker_pos = byte_pos;
                    scan_phase = SCAN_TYPE;
                end else begin
                    len_hi     = b;
                    scan_phase = SCAN_LEN_LO;
                end
            end
            SCAN_LEN_LO: begin
                declared = {1'b0, len_hi, b};
                if (declared < 17'd2) declared = 17'd2;
                chunk_done = 1'b1;
                chunk_size = declared + 17'd2;
                skip_left  = declared[15:0] - 16'd2;
                scan_phase = (skip_left != 0) ? SCAN_SKIP : SCAN_HUNT;
            end
            SCAN_SKIP: begin
                skip_left = skip_left - 16'd1;
                if (skip_left == 0) scan_phase = SCAN_HUNT;
            end
            default: begin
                if (b == MarkerPrefix) begin
                    marker_pos = byte_pos;
                    scan_phase = SCAN_TYPE;
                end
            end
        endcase
        byte_pos = byte_pos + 32'd1;

        if (chunk_done && (wanted_cfg == NoType || wanted_cfg == cur_type)) begin
            res.status       = StatusFound;
            res.marker_type  = cur_type;
            res.start_offset = chunk_start;
            res.chunk_length = chunk_size;
            res.end_offset   = chunk_start + {15'd0, chunk_size};
            res.last_result  = !stream_end;
            pending_results.push_back(res);
        end
        if (stream_end) begin
            res = '0;
            res.status      = StatusEnd;
            res.last_result = 1'b1;
            pending_results.push_back(res);
            clear_scan();
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [7:0] b, input logic stream_end);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= stream_end;
        do @(posedge i_clk); while (!s_axis_tready);
        scan_byte(b, stream_end);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_bytes.size(); i++) begin
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
        end
        wait_idle();
    endtask

    task automatic write_wanted(input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        wanted_cfg = value;
    endtask

    task automatic test_special_cases();
        send_gap_max   = 14;
        recv_stall_max = 14;
        write_wanted(8'h00);
        // Noise, zero type byte, two-byte chunk, type 0xFF with a short length,
        // a skipped body, and a chunk that ends on the stream_end byte.
        stream_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hD8, 8'hFF, 8'hFF, 8'h00, 8'h01,
                         8'hFF, 8'hE0, 8'h00, 8'h05, 8'hFF, 8'hAA, 8'h55,
                         8'hFF, 8'hC4, 8'h00, 8'h02};
        send_stream();
        // A marker whose size is still unknown at stream end.
        stream_bytes = '{8'hFF, 8'hE1, 8'h00};
        send_stream();
        // A two-byte chunk completed by the final byte.
        stream_bytes = '{8'hFF, 8'hD8, 8'hFF};
        send_stream();
    endtask

    task automatic test_type_filter();
        send_gap_max   = 0;
        recv_stall_max = 14;
        write_wanted(8'hE0);
        stream_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h02, 8'hFF, 8'hDB, 8'h00,
                         8'h03, 8'h77, 8'hFF, 8'hE0, 8'h00, 8'h00};
        send_stream();
        send_gap_max   = 14;
        recv_stall_max = 0;
        write_wanted(8'hFF);
        stream_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h02};
        send_stream();
    endtask

    // Long declared length of 0xFEFF, giving a chunk size of 0xFF01 in chunk_length.
    // The stream ends inside the body, which is reported once the length is known.
    task automatic test_long_chunk();
        send_gap_max   = 0;
        recv_stall_max = 0;
        write_wanted(8'hC0);
        stream_bytes = '{8'hFF, 8'hC0, 8'hFE, 8'hFF, 8'($urandom), 8'($urandom)};
        send_stream();
    endtask

    task automatic test_random_streams();
        logic [7:0] common_types[6];
        logic [7:0] t;
        logic [7:0] lo;
        logic [7:0] hi;
        int         sent;
        int         nseg;
        int         kind;
        int         body;
        int         cut;
        bit         need_marker;
        common_types = '{8'hD8, 8'hE0, 8'hDB, 8'hC4, 8'hDA, 8'hFE};
        sent = 0;
        while (sent < RandomBytes) begin
            case ($urandom_range(0, 4))
                0, 1: write_wanted(8'h00);
                2:    write_wanted(common_types[$urandom_range(0, 5)]);
                3:    write_wanted(8'($urandom));
                default: write_wanted(8'hFF);
            endcase
            send_gap_max   = $urandom_range(0, 1) ? 14 : 0;
            recv_stall_max = $urandom_range(0, 1) ? 14 : 0;

            stream_bytes.delete();
            need_marker = 1'b0;
            nseg = $urandom_range(1, 10);
            for (int s = 0; s < nseg; s++) begin
                kind = need_marker ? $urandom_range(30, 99) : $urandom_range(0, 99);
                need_marker = 1'b0;
                t = $urandom_range(0, 1) ? common_types[$urandom_range(0, 5)]
                                         : 8'($urandom_range(1, 255));
                if (kind < 10) begin
                    repeat ($urandom_range(1, 3)) stream_bytes.push_back(8'($urandom));
                end else if (kind < 15) begin
                    stream_bytes.push_back(MarkerPrefix);
                    stream_bytes.push_back(NoType);
                end else if (kind < 30) begin
                    // Standalone marker: the next byte must open another marker.
                    stream_bytes.push_back(MarkerPrefix);
                    stream_bytes.push_back(t);
                    need_marker = 1'b1;
                end else begin
                    hi = ($urandom_range(0, 99) < 3) ? 8'h01 : 8'h00;
                    lo = (hi != 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
                    body = int'({hi, lo});
                    body = (body < 2) ? 0 : body - 2;
                    stream_bytes.push_back(MarkerPrefix);
                    stream_bytes.push_back(t);
                    stream_bytes.push_back(hi);
                    stream_bytes.push_back(lo);
                    repeat (body) stream_bytes.push_back(8'($urandom));
                end
            end
            // Some streams end in the middle of a chunk.
            if ($urandom_range(0, 4) == 0 && stream_bytes.size() > 1) begin
                cut = $urandom_range(1, stream_bytes.size() - 1);
                while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
            end
            sent += stream_bytes.size();
            send_stream();
        end
    endtask

    task automatic test_filter_reload();
        write_wanted(8'h01);
        stream_bytes = '{8'hFF, 8'h01, 8'hFF, 8'h02, 8'h00, 8'h02, 8'hFF, 8'h01, 8'h00,
                         8'h04, 8'h12, 8'h34};
        send_stream();
    endtask

    // Receiver: a random stall before each transaction on the master side.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = $urandom_range(0, recv_stall_max);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (expv !== actv) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual tdata %0h status %0b",
                         $time, m_axis_tdata, m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(m_axis_tuser));
                check_field("marker_type", 32'(want.marker_type), 32'(m_axis_tdata[7:0]));
                check_field("start_offset", want.start_offset, m_axis_tdata[39:8]);
                check_field("chunk_length", 32'(want.chunk_length),
                            32'(m_axis_tdata[56:40]));
                check_field("end_offset", want.end_offset, m_axis_tdata[88:57]);
                check_field("last_result", 32'(want.last_result), 32'(m_axis_tlast));
                check_field("tdata padding", '0, 32'(m_axis_tdata[OutDataBits-1:89]));
            end
        end
    end

    // Watchdog.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t ns: timeout with %0d results outstanding", $time, pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        fail_count     = 0;
        send_gap_max   = 0;
        recv_stall_max = 0;
        wanted_cfg     = 8'h00;
        clear_scan();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 8'h00;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_special_cases();
        test_type_filter();
        test_long_chunk();
        test_random_streams();
        test_filter_reload();

        wait_idle();
        repeat (SettleCycles) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
